// ===== src/itra_pkg.sv =====
package itra_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS_DEF = 22;
  localparam int MAX_WIDTH_DEF  = 62;

  localparam int DIGIT_W = 4;
  localparam int WIDTH_W = 6;
  localparam int LIMIT_W = 5;

  // base_sel codes of the input transaction
  localparam logic [1:0] BASE_OCT = 2'd0;
  localparam logic [1:0] BASE_DEC = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_UP_A  = 8'h41;
  localparam logic [7:0] CHAR_LO_A  = 8'h61;

  typedef enum logic [1:0] {
    RADIX_OCT,
    RADIX_DEC,
    RADIX_HEX
  } radix_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_PREP,
    ST_SIGN,
    ST_PAD,
    ST_DIGIT
  } state_e;

  typedef struct packed {
    logic   load;
    logic   start;
    radix_e radix;
  } div_cmd_t;

  typedef struct packed {
    logic               done;
    logic [DIGIT_W-1:0] digit;
    logic               q_zero;
  } div_sts_t;

  function automatic logic [7:0] digit_char(input logic [DIGIT_W-1:0] d, input logic upper);
    logic [7:0] base_ch;
    begin
      if (d < DIGIT_W'(10)) begin
        digit_char = CHAR_ZERO + {4'b0, d};
      end else begin
        base_ch    = upper ? CHAR_UP_A : CHAR_LO_A;
        digit_char = base_ch + {4'b0, d} - 8'd10;
      end
    end
  endfunction

endpackage

// ===== src/itra_div.sv =====
// one digit per start: shift for octal/hex, bit-serial long division for decimal
module itra_div import itra_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  div_cmd_t              cmd_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output div_sts_t              sts_o
);

  localparam int CNT_W = $clog2(VALUE_BITS);

  logic [VALUE_BITS-1:0] q_q;
  logic [DIGIT_W-1:0]    r_q;
  logic [DIGIT_W-1:0]    digit_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [DIGIT_W:0]      r_shift;
  logic                  q_bit;
  logic [DIGIT_W-1:0]    r_next;

  // partial remainder stays below ten, so one compare and subtract per bit
  assign r_shift = {r_q, q_q[VALUE_BITS-1]};
  assign q_bit   = (r_shift >= (DIGIT_W+1)'(10));
  assign r_next  = q_bit ? DIGIT_W'(r_shift - (DIGIT_W+1)'(10)) : r_shift[DIGIT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (cmd_i.start && cmd_i.radix == RADIX_DEC) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (cmd_i.start) begin
        done_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q <= value_i;
    end else if (cmd_i.start) begin
      case (cmd_i.radix)
        RADIX_OCT: begin
          digit_q <= {1'b0, q_q[2:0]};
          q_q     <= q_q >> 3;
        end
        RADIX_DEC: begin
          r_q <= '0;
        end
        default: begin
          digit_q <= q_q[3:0];
          q_q     <= q_q >> 4;
        end
      endcase
    end else if (busy_q) begin
      r_q <= r_next;
      q_q <= {q_q[VALUE_BITS-2:0], q_bit};
      if (cnt_q == CNT_W'(VALUE_BITS - 1)) begin
        digit_q <= r_next;
      end
    end
  end

  assign sts_o.done   = done_q;
  assign sts_o.digit  = digit_q;
  assign sts_o.q_zero = (q_q == '0);

endmodule

// ===== src/itra_stack.sv =====
// digit stack: digits pushed least significant first, popped most significant first
module itra_stack import itra_pkg::*; #(
  parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               push_i,
  input  logic               pop_i,
  input  logic [DIGIT_W-1:0] digit_i,
  output logic [DIGIT_W-1:0] top_o
);

  logic [DIGIT_W-1:0] st_q [MAX_DIGITS];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      st_q[0] <= digit_i;
      for (int i = 1; i < MAX_DIGITS; i++) begin
        st_q[i] <= st_q[i-1];
      end
    end else if (pop_i) begin
      for (int i = 0; i < MAX_DIGITS - 1; i++) begin
        st_q[i] <= st_q[i+1];
      end
    end
  end

  assign top_o = st_q[0];

endmodule

// ===== src/integer_to_radix_ascii_unit.sv =====
// octal/hex digits come from a shift, decimal digits from bit-serial long division
// by ten; then a prep state, then one character per cycle while the output is not stalled
// throughput: one number at a time; the next transaction is taken once the last
// character is loaded into the output register
// reset: rst_ni asynchronous active low clears the sequencer, counters and output valid
module integer_to_radix_ascii_unit import itra_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int MAX_DIGITS = MAX_DIGITS_DEF,
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // value[63:0], base_sel[65:64], is_signed[66], min_width[72:67], pad_zero[73],
  // upper_case[74], digit_limit[79:75]
  input  logic [79:0] s_axis_tdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // out_char[7:0]
  output logic [7:0]  m_axis_tdata,
  output logic        m_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready
);

  localparam int DCNT_W = $clog2(MAX_DIGITS + 1);

  // input fields
  logic [VALUE_BITS-1:0] in_value;
  logic [1:0]            in_base;
  logic                  in_signed;
  logic [WIDTH_W-1:0]    in_width;
  logic                  in_padz;
  logic                  in_upper;
  logic [LIMIT_W-1:0]    in_limit;

  assign in_value  = s_axis_tdata[VALUE_BITS-1:0];
  assign in_base   = s_axis_tdata[65:64];
  assign in_signed = s_axis_tdata[66];
  assign in_width  = s_axis_tdata[72:67];
  assign in_padz   = s_axis_tdata[73];
  assign in_upper  = s_axis_tdata[74];
  assign in_limit  = s_axis_tdata[79:75];

  state_e             state_q, state_d;
  logic               neg_q;
  radix_e             radix_q;
  logic               upper_q;
  logic               padz_q;
  logic [WIDTH_W-1:0] width_q;
  logic [DCNT_W-1:0]  lim_q;
  logic [DCNT_W-1:0]  dcnt_q;
  logic [WIDTH_W-1:0] pad_cnt_q;
  logic               m_valid_q;
  logic [7:0]         m_data_q;
  logic               m_last_q;

  logic                  in_acc;
  logic                  out_free;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  radix_e                in_radix;
  logic [WIDTH_W-1:0]    pad_calc;
  logic [WIDTH_W-1:0]    dcnt_ext;
  logic                  lim_hit;

  div_cmd_t           div_cmd;
  div_sts_t           div_sts;
  logic               push;
  logic               pop;
  logic [DIGIT_W-1:0] top_digit;

  logic               out_load;
  logic [7:0]         out_char;
  logic               out_last;

  assign in_acc   = s_axis_tvalid && s_axis_tready;
  // output register takes a new character when empty or being drained this cycle
  assign out_free = !m_valid_q || m_axis_tready;

  // sign test and negation at the full value width
  assign in_neg = in_signed && in_value[VALUE_BITS-1];
  assign in_mag = in_neg ? (~in_value + 1'b1) : in_value;

  always_comb begin
    case (in_base)
      BASE_OCT: in_radix = RADIX_OCT;
      BASE_DEC: in_radix = RADIX_DEC;
      default:  in_radix = RADIX_HEX;  // unused code behaves as hex
    endcase
  end

  assign dcnt_ext = WIDTH_W'(dcnt_q);
  assign pad_calc = (width_q > dcnt_ext) ? (width_q - dcnt_ext) : '0;
  assign lim_hit  = (DCNT_W'(dcnt_q + 1'b1) == lim_q);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) state_d = ST_START;
      end
      ST_START: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        if (div_sts.done) begin
          state_d = (div_sts.q_zero || lim_hit) ? ST_PREP : ST_START;
        end
      end
      ST_PREP: begin
        if (neg_q)                state_d = ST_SIGN;
        else if (pad_calc != '0)  state_d = ST_PAD;
        else                      state_d = ST_DIGIT;
      end
      ST_SIGN: begin
        if (out_free) state_d = (pad_cnt_q != '0) ? ST_PAD : ST_DIGIT;
      end
      ST_PAD: begin
        if (out_free && pad_cnt_q == WIDTH_W'(1)) state_d = ST_DIGIT;
      end
      ST_DIGIT: begin
        if (out_free && dcnt_q == DCNT_W'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    s_axis_tready = 1'b0;
    div_cmd.load  = 1'b0;
    div_cmd.start = 1'b0;
    div_cmd.radix = radix_q;
    push          = 1'b0;
    pop           = 1'b0;
    out_load      = 1'b0;
    out_char      = CHAR_MINUS;
    out_last      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_cmd.load  = in_acc;
      end
      ST_START: begin
        div_cmd.start = 1'b1;
      end
      ST_WAIT: begin
        push = div_sts.done;
      end
      ST_SIGN: begin
        out_load = out_free;
      end
      ST_PAD: begin
        out_load = out_free;
        out_char = padz_q ? CHAR_ZERO : CHAR_SPACE;
      end
      ST_DIGIT: begin
        out_load = out_free;
        pop      = out_free;
        out_char = digit_char(top_digit, upper_q);
        out_last = (dcnt_q == DCNT_W'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      neg_q     <= 1'b0;
      radix_q   <= RADIX_DEC;
      upper_q   <= 1'b0;
      padz_q    <= 1'b0;
      width_q   <= '0;
      lim_q     <= '0;
      dcnt_q    <= '0;
      pad_cnt_q <= '0;
      m_valid_q <= 1'b0;
      m_last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc) begin
        neg_q   <= in_neg;
        radix_q <= in_radix;
        upper_q <= in_upper;
        padz_q  <= in_padz;
        // width saturates, a zero or oversized limit means the full digit count
        width_q <= (in_width > WIDTH_W'(MAX_WIDTH)) ? WIDTH_W'(MAX_WIDTH) : in_width;
        lim_q   <= (in_limit == '0 || in_limit > LIMIT_W'(MAX_DIGITS)) ?
                   DCNT_W'(MAX_DIGITS) : DCNT_W'(in_limit);
        dcnt_q  <= '0;
      end else if (push) begin
        dcnt_q <= dcnt_q + 1'b1;
      end else if (pop) begin
        dcnt_q <= dcnt_q - 1'b1;
      end
      if (state_q == ST_PREP) begin
        pad_cnt_q <= pad_calc;
      end else if (state_q == ST_PAD && out_free) begin
        pad_cnt_q <= pad_cnt_q - 1'b1;
      end
      if (out_load) begin
        m_valid_q <= 1'b1;
        m_last_q  <= out_last;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) m_data_q <= out_char;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;

  itra_div #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .value_i(in_mag),
    .sts_o  (div_sts)
  );

  itra_stack #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_stack (
    .clk_i  (clk_i),
    .push_i (push),
    .pop_i  (pop),
    .digit_i(div_sts.digit),
    .top_o  (top_digit)
  );

  // digit collection never runs past the limit
  a_dcnt_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WAIT) |-> (dcnt_q < lim_q))
    else $error("digit count reached limit while dividing");

  // digit emission only with digits left on the stack
  a_digits_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIGIT) |-> (dcnt_q != '0))
    else $error("digit emission with empty stack");

  // padding phase only with pad characters outstanding
  a_pad_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PAD) |-> (pad_cnt_q != '0))
    else $error("pad phase with zero pad count");

  // the final character of a number is always a digit
  a_last_after_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last) |-> (state_q == ST_DIGIT))
    else $error("last flag outside digit phase");

endmodule

// ===== test/tb_integer_to_radix_ascii_unit.sv =====
`timescale 1ns / 100ps

module tb_integer_to_radix_ascii_unit;
  import itra_pkg::*;

  localparam int WATCHDOG_LIMIT = 6000;  // decimal takes longest per digit, 20 digits at most
  localparam int DRAIN_CYCLES   = 100;
  localparam int RANDOM_NUMBERS = 96;
  localparam int SAT_WIDTH      = 62;
  localparam int SAT_DIGITS     = 22;

  // one input transaction; the first declared field lands in the top bits
  typedef struct packed {
    logic [4:0]  digit_limit;
    logic        upper_case;
    logic        pad_zero;
    logic [5:0]  min_width;
    logic        is_signed;
    logic [1:0]  base_sel;
    logic [63:0] value;
  } number_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  // formats each accepted number on its own and checks the character stream
  class text_checker;
    text_char_t expected_chars[$];
    int         errors;

    function void flag(string msg);
      errors++;
      if (errors <= 10) $display("mismatch: %s", msg);
    endfunction

    function void note_number(number_req_t req);
      logic [63:0] mag;
      logic [3:0]  digits[$];
      int          radix;
      int          width;
      int          limit;
      int          pads;
      logic        neg;
      text_char_t  tc;
      radix = (req.base_sel == BASE_OCT) ? 8 : (req.base_sel == BASE_DEC) ? 10 : 16;
      width = (req.min_width > SAT_WIDTH) ? SAT_WIDTH : req.min_width;
      limit = (req.digit_limit == 0 || req.digit_limit > SAT_DIGITS) ? SAT_DIGITS
                                                                      : req.digit_limit;
      neg   = req.is_signed && req.value[63];
      mag   = neg ? (~req.value + 64'd1) : req.value;
      // least significant digit first; at least one digit even for zero
      do begin
        digits.push_back(4'(mag % radix));
        mag = mag / radix;
      end while (mag != 0 && digits.size() < limit);
      pads = (width > digits.size()) ? width - digits.size() : 0;
      tc.last = 1'b0;
      if (neg) begin
        tc.ch = CHAR_MINUS;
        expected_chars.push_back(tc);
      end
      repeat (pads) begin
        tc.ch = req.pad_zero ? CHAR_ZERO : CHAR_SPACE;
        expected_chars.push_back(tc);
      end
      while (digits.size() != 0) begin
        tc.ch = (digits[$] < 10) ? CHAR_ZERO + 8'(digits[$])
              : (req.upper_case ? CHAR_UP_A : CHAR_LO_A) + 8'(digits[$]) - 8'd10;
        tc.last = (digits.size() == 1);
        expected_chars.push_back(tc);
        void'(digits.pop_back());
      end
    endfunction

    function void check_char(logic [7:0] ch, logic last);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        flag($sformatf("unexpected char %h last %b", ch, last));
        return;
      end
      want = expected_chars.pop_front();
      if (ch !== want.ch || last !== want.last)
        flag($sformatf("expected char %h last %b, got char %h last %b",
                       want.ch, want.last, ch, last));
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [79:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;

  int          send_idle_pct = 12;
  int          recv_idle_pct = 84;
  int          quiet_cycles = 0;
  text_checker board = new();

  integer_to_radix_ascii_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // output side: check each character transaction, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      board.check_char(m_axis_tdata, m_axis_tlast);
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_integer_to_radix_ascii_unit failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic number_req_t mk(logic [63:0] v, logic [1:0] b, logic sg, logic [5:0] w,
                                     logic pz, logic up, logic [4:0] lim);
    number_req_t r;
    r.value       = v;
    r.base_sel    = b;
    r.is_signed   = sg;
    r.min_width   = w;
    r.pad_zero    = pz;
    r.upper_case  = up;
    r.digit_limit = lim;
    return r;
  endfunction

  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    int          k;
    k = $urandom_range(31);
    case ($urandom_range(5))
      0: v = {$urandom(), $urandom()};
      1: v = 64'($urandom_range(999));
      2: v = -64'($urandom_range(1000, 1));
      3: v = 64'h8000_0000_0000_0000 + 64'($urandom_range(8)) - 64'd4;
      4: v = (64'd1 << (k * 2 + $urandom_range(1))) - 64'($urandom_range(1));
      default: v = {32'd0, $urandom()};
    endcase
    return v;
  endfunction

  function automatic number_req_t pick_number();
    number_req_t r;
    r.value       = pick_value();
    r.base_sel    = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
    r.is_signed   = 1'($urandom_range(1));
    r.min_width   = ($urandom_range(4) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(24));
    r.pad_zero    = 1'($urandom_range(1));
    r.upper_case  = 1'($urandom_range(1));
    r.digit_limit = ($urandom_range(2) == 0) ? 5'($urandom_range(31)) : 5'd0;
    return r;
  endfunction

  // present one number, hold it until the block takes it
  task automatic send_number(number_req_t req);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata  <= req;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_number(req);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero, extremes of every field, each radix and the corner cases
    send_number(mk(64'd0, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk(64'd0, BASE_HEX, 1'b1, 6'd1, 1'b1, 1'b1, 5'd1));
    send_number(mk('1, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk('1, BASE_DEC, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0));
    // most negative value, magnitude printed in full
    send_number(mk(64'h8000_0000_0000_0000, BASE_DEC, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk(64'h8000_0000_0000_0000, BASE_OCT, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk(64'h8000_0000_0000_0000, BASE_HEX, 1'b1, 6'd0, 1'b0, 1'b1, 5'd0));
    send_number(mk('1, BASE_OCT, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk('1, BASE_HEX, 1'b0, 6'd0, 1'b0, 1'b1, 5'd0));
    send_number(mk(64'h00ab_cdef, BASE_HEX, 1'b0, 6'd8, 1'b1, 1'b0, 5'd0));
    send_number(mk(64'h00ab_cdef, BASE_HEX, 1'b0, 6'd8, 1'b0, 1'b1, 5'd0));
    // unused radix code behaves as hex
    send_number(mk(64'hfedc_ba98_7654_3210, 2'd3, 1'b0, 6'd0, 1'b0, 1'b0, 5'd0));
    // width beyond the maximum saturates; sign sits ahead of the padding
    send_number(mk(-64'd12345, BASE_DEC, 1'b1, 6'd63, 1'b1, 1'b0, 5'd0));
    send_number(mk(64'd7, BASE_OCT, 1'b0, 6'd62, 1'b0, 1'b0, 5'd0));
    send_number(mk(-64'd7, BASE_HEX, 1'b1, 6'd63, 1'b0, 1'b0, 5'd31));
    // digit limits: truncation, oversize, exact maximum
    send_number(mk(64'd987654321, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0, 5'd1));
    send_number(mk(64'd987654321, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0, 5'd5));
    send_number(mk('1, BASE_DEC, 1'b0, 6'd0, 1'b0, 1'b0, 5'd31));
    send_number(mk('1, BASE_OCT, 1'b0, 6'd30, 1'b1, 1'b0, 5'd22));
    send_number(mk(64'o7654321, BASE_OCT, 1'b1, 6'd10, 1'b1, 1'b0, 5'd3));
    send_number(mk(-64'd98765, BASE_DEC, 1'b1, 6'd4, 1'b0, 1'b0, 5'd2));
    // 32-bit sign position must not count as negative at 64 bits
    send_number(mk(64'h0000_0000_8000_0000, BASE_DEC, 1'b1, 6'd0, 1'b0, 1'b0, 5'd0));
    send_number(mk(64'hffff_ffff_0000_0000, BASE_HEX, 1'b1, 6'd0, 1'b0, 1'b1, 5'd0));
    send_number(mk(64'h7fff_ffff_ffff_ffff, BASE_DEC, 1'b1, 6'd21, 1'b1, 1'b0, 5'd0));

    // hold the sender off until every character of the directed part is out
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 84 : 0;
      recv_idle_pct = (phase == 0) ? 84 : (phase == 1) ? 12 : 0;
      repeat (RANDOM_NUMBERS / 3) send_number(pick_number());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("tb_integer_to_radix_ascii_unit passed");
    end else begin
      $display("tb_integer_to_radix_ascii_unit failed");
    end
    $finish;
  end

endmodule
